### hdl/stsup_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Torque supervisor package
// Shared widths, codes, reset values and the drive status decoder.
// ----------------------------------------------------------------------------
package stsup_pkg;

	localparam int MAX_JOINTS_DEF   = 8;
	localparam int TORQUE_WIDTH_DEF = 24;

	localparam int SCALE_W  = 17;
	localparam int SW_W     = 16;
	localparam int PERIOD_W = 16;
	localparam int EFFORT_W = 23;
	localparam int SLEW_W   = 24;
	localparam int JIDX_W   = 3;
	localparam int JCNT_W   = 4;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 3;
	localparam int STEP_W   = 3;

	localparam logic [SCALE_W-1:0]  SCALE_ONE       = 17'd65536;
	localparam logic [EFFORT_W-1:0] EFFORT_RST      = '1;
	localparam logic [SLEW_W-1:0]   SLEW_RST        = '1;
	localparam logic [SLEW_W-1:0]   FAULT_SLEW_RST  = 24'd1024;
	localparam logic [JCNT_W-1:0]   JOINT_COUNT_RST = 4'd6;

	localparam logic [CFG_IDX_W-1:0] REG_JOINT_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAULT_SLEW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_JOINT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_EFFORT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_SLEW   = 3'd4;

	localparam logic [SW_W-1:0] SW_MASK_A      = 16'h004F;
	localparam logic [SW_W-1:0] SW_MASK_B      = 16'h006F;
	localparam logic [SW_W-1:0] SW_NOT_READY   = 16'h0000;
	localparam logic [SW_W-1:0] SW_SOD         = 16'h0040;
	localparam logic [SW_W-1:0] SW_READY       = 16'h0021;
	localparam logic [SW_W-1:0] SW_SWITCHED_ON = 16'h0023;
	localparam logic [SW_W-1:0] SW_OP_ENABLED  = 16'h0027;
	localparam logic [SW_W-1:0] SW_QUICK_STOP  = 16'h0007;
	localparam logic [SW_W-1:0] SW_FAULT_REACT = 16'h000F;
	localparam logic [SW_W-1:0] SW_FAULT       = 16'h0008;

	typedef enum logic [3:0] {
		DS_UNKNOWN,
		DS_NOT_READY,
		DS_SOD,
		DS_READY,
		DS_SWITCHED_ON,
		DS_OP_ENABLED,
		DS_QUICK_STOP,
		DS_FAULT_REACTION,
		DS_FAULT
	} drive_state_t;

	typedef enum logic [STEP_W-1:0] {
		SS_OK,
		SS_LATCHED,
		SS_FAULT,
		SS_REACTION,
		SS_INVALID,
		SS_DISABLE
	} step_status_t;

	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_ZERO,
		ACT_RAMP,
		ACT_SLEW
	} act_t;

	typedef struct packed {
		logic badscale;
		logic terminal;
		logic unknown;
		logic reaction;
		logic fault;
		logic enabled;
	} flags_t;

	localparam flags_t FLAGS_RST = '{badscale: 1'b0, terminal: 1'b1, unknown: 1'b0,
		reaction: 1'b0, fault: 1'b0, enabled: 1'b0};

	typedef struct packed {
		logic mul_en;
		act_t act;
	} calc_ctl_t;

	function automatic drive_state_t drive_state_of(input logic [SW_W-1:0] sw);
		logic [SW_W-1:0] a;
		logic [SW_W-1:0] b;
		drive_state_t    s;
		a = sw & SW_MASK_A;
		b = sw & SW_MASK_B;
		if (a == SW_NOT_READY)        s = DS_NOT_READY;
		else if (a == SW_SOD)         s = DS_SOD;
		else if (b == SW_READY)       s = DS_READY;
		else if (b == SW_SWITCHED_ON) s = DS_SWITCHED_ON;
		else if (b == SW_OP_ENABLED)  s = DS_OP_ENABLED;
		else if (b == SW_QUICK_STOP)  s = DS_QUICK_STOP;
		else if (a == SW_FAULT_REACT) s = DS_FAULT_REACTION;
		else if (a == SW_FAULT)       s = DS_FAULT;
		else                          s = DS_UNKNOWN;
		return s;
	endfunction

endpackage
`default_nettype wire

### hdl/stsup_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Joint item channel
// Valid/ready channel that carries one joint word.
// ----------------------------------------------------------------------------
interface stsup_in_if #(
	parameter int TORQUE_WIDTH = stsup_pkg::TORQUE_WIDTH_DEF
) ();
	logic                                  valid;
	logic                                  ready;
	logic signed [TORQUE_WIDTH-1:0]        gravity_torque;
	logic [stsup_pkg::SCALE_W-1:0]         gain_scale;
	logic [stsup_pkg::SW_W-1:0]            status_word;
	logic                                  model_ok;
	logic [stsup_pkg::PERIOD_W-1:0]        period;
	logic                                  last_joint;

	modport source (output valid, gravity_torque, gain_scale, status_word, model_ok,
		period, last_joint, input ready);
	modport sink (input valid, gravity_torque, gain_scale, status_word, model_ok,
		period, last_joint, output ready);
endinterface
`default_nettype wire

### hdl/stsup_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface stsup_out_if #(
	parameter int TORQUE_WIDTH = stsup_pkg::TORQUE_WIDTH_DEF
) ();
	logic                              valid;
	logic                              ready;
	logic [stsup_pkg::JIDX_W-1:0]      joint_index;
	logic signed [TORQUE_WIDTH-1:0]    torque_out;
	logic [stsup_pkg::STEP_W-1:0]      step_status;
	logic                              last_result;

	modport source (output valid, joint_index, torque_out, step_status, last_result,
		input ready);
	modport sink (input valid, joint_index, torque_out, step_status, last_result,
		output ready);
endinterface
`default_nettype wire

### hdl/stsup_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Supervisor joint memories
// Item buffer, output torque store and limit tables, all with registered reads.
// ----------------------------------------------------------------------------
module stsup_mem #(
	parameter int MAX_JOINTS   = stsup_pkg::MAX_JOINTS_DEF,
	parameter int TORQUE_WIDTH = stsup_pkg::TORQUE_WIDTH_DEF,
	localparam int AW          = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                buf_we,
	input  wire logic [AW-1:0]                       buf_waddr,
	input  wire logic [TORQUE_WIDTH-1:0]             buf_wgrav,
	input  wire logic [stsup_pkg::SCALE_W-1:0]       buf_wscale,
	input  wire logic                                lim_we,
	input  wire logic [AW-1:0]                       lim_waddr,
	input  wire logic [stsup_pkg::EFFORT_W-1:0]      lim_weffort,
	input  wire logic [stsup_pkg::SLEW_W-1:0]        lim_wslew,
	input  wire logic                                tq_we,
	input  wire logic [AW-1:0]                       tq_waddr,
	input  wire logic [TORQUE_WIDTH-1:0]             tq_wdata,
	input  wire logic                                tq_clear,
	input  wire logic [AW-1:0]                       rd_addr,
	output logic [TORQUE_WIDTH-1:0]                  rd_grav,
	output logic [stsup_pkg::SCALE_W-1:0]            rd_scale,
	output logic [stsup_pkg::EFFORT_W-1:0]           rd_effort,
	output logic [stsup_pkg::SLEW_W-1:0]             rd_slew,
	output logic [TORQUE_WIDTH-1:0]                  rd_torque
);
	logic [TORQUE_WIDTH-1:0]           grav_mem  [MAX_JOINTS];
	logic [stsup_pkg::SCALE_W-1:0]     scale_mem [MAX_JOINTS];
	logic [TORQUE_WIDTH-1:0]           tq_mem    [MAX_JOINTS];
	logic [stsup_pkg::EFFORT_W-1:0]    eff_mem   [MAX_JOINTS];
	logic [stsup_pkg::SLEW_W-1:0]      slw_mem   [MAX_JOINTS];

	logic [MAX_JOINTS-1:0]             tq_vld_q;
	logic [MAX_JOINTS-1:0]             lim_vld_q;
	logic                              rd_tqv_q;
	logic                              rd_limv_q;
	logic [TORQUE_WIDTH-1:0]           rd_grav_q;
	logic [stsup_pkg::SCALE_W-1:0]     rd_scale_q;
	logic [TORQUE_WIDTH-1:0]           rd_tq_q;
	logic [stsup_pkg::EFFORT_W-1:0]    rd_eff_q;
	logic [stsup_pkg::SLEW_W-1:0]      rd_slw_q;

	always_ff @(posedge clk) begin
		if (buf_we) begin
			grav_mem[buf_waddr]  <= buf_wgrav;
			scale_mem[buf_waddr] <= buf_wscale;
		end
		if (lim_we) begin
			eff_mem[lim_waddr] <= lim_weffort;
			slw_mem[lim_waddr] <= lim_wslew;
		end
		if (tq_we) begin
			tq_mem[tq_waddr] <= tq_wdata;
		end
		rd_grav_q  <= grav_mem[rd_addr];
		rd_scale_q <= scale_mem[rd_addr];
		rd_tq_q    <= tq_mem[rd_addr];
		rd_eff_q   <= eff_mem[rd_addr];
		rd_slw_q   <= slw_mem[rd_addr];
	end

	// Entries without a valid bit read as their reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tq_vld_q  <= '0;
			lim_vld_q <= '0;
			rd_tqv_q  <= 1'b0;
			rd_limv_q <= 1'b0;
		end else begin
			if (tq_clear) begin
				tq_vld_q <= '0;
			end else if (tq_we) begin
				tq_vld_q[tq_waddr] <= 1'b1;
			end
			if (lim_we) begin
				lim_vld_q[lim_waddr] <= 1'b1;
			end
			rd_tqv_q  <= tq_vld_q[rd_addr];
			rd_limv_q <= lim_vld_q[rd_addr];
		end
	end

	assign rd_grav   = rd_grav_q;
	assign rd_scale  = rd_scale_q;
	assign rd_torque = rd_tqv_q ? rd_tq_q : '0;
	assign rd_effort = rd_limv_q ? rd_eff_q : stsup_pkg::EFFORT_RST;
	assign rd_slew   = rd_limv_q ? rd_slw_q : stsup_pkg::SLEW_RST;
endmodule
`default_nettype wire

### hdl/stsup_calc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Supervisor torque update
// Registered products, then rounding, effort clamp and slew limiting.
// ----------------------------------------------------------------------------
module stsup_calc #(
	parameter int TORQUE_WIDTH = stsup_pkg::TORQUE_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire stsup_pkg::calc_ctl_t              ctl,
	input  wire logic [TORQUE_WIDTH-1:0]           gravity,
	input  wire logic [stsup_pkg::SCALE_W-1:0]     scale,
	input  wire logic [stsup_pkg::EFFORT_W-1:0]    effort,
	input  wire logic [stsup_pkg::SLEW_W-1:0]      slew_tab,
	input  wire logic [stsup_pkg::SLEW_W-1:0]      fault_slew,
	input  wire logic [stsup_pkg::PERIOD_W-1:0]    period,
	input  wire logic [TORQUE_WIDTH-1:0]           cur_torque,
	output logic [TORQUE_WIDTH-1:0]                new_torque
);
	localparam int PW  = stsup_pkg::SCALE_W + TORQUE_WIDTH;
	localparam int CW  = (TORQUE_WIDTH + 2 > 24) ? TORQUE_WIDTH + 2 : 24;
	localparam int MW  = stsup_pkg::SLEW_W + stsup_pkg::PERIOD_W;
	localparam int CHW = MW - 19;
	localparam logic [CW-1:0] TMAX = CW'((64'd1 << (TORQUE_WIDTH - 1)) - 64'd1);

	logic [TORQUE_WIDTH-1:0]  mag;
	logic [stsup_pkg::SLEW_W-1:0] sel_slew;
	logic [PW-1:0]            prod_s2;
	logic [MW-1:0]            chg_s2;
	logic                     neg_s2;
	logic [stsup_pkg::EFFORT_W-1:0] eff_s2;
	logic [TORQUE_WIDTH-1:0]  cur_s2;

	logic [PW:0]              rsum;
	logic [CW-1:0]            q;
	logic [CW-1:0]            lim;
	logic [CW-1:0]            mq;
	logic [MW:0]              csum;
	logic [CHW-1:0]           change;
	logic signed [CW-1:0]     tgt;
	logic signed [CW-1:0]     cur_e;
	logic signed [CW-1:0]     chg_e;
	logic signed [CW-1:0]     d;
	logic signed [CW-1:0]     nxt;

	assign mag      = gravity[TORQUE_WIDTH-1] ? (~gravity + 1'b1) : gravity;
	assign sel_slew = (ctl.act == stsup_pkg::ACT_RAMP) ? fault_slew : slew_tab;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s2 <= PW'(scale) * PW'(mag);
			chg_s2  <= MW'(sel_slew) * MW'(period);
			neg_s2  <= gravity[TORQUE_WIDTH-1];
			eff_s2  <= effort;
			cur_s2  <= cur_torque;
		end
	end

	always_comb begin
		rsum   = {1'b0, prod_s2} + (PW+1)'(32768);
		q      = CW'(rsum[PW:16]);
		lim    = (CW'(eff_s2) > TMAX) ? TMAX : CW'(eff_s2);
		mq     = (q > lim) ? lim : q;
		csum   = {1'b0, chg_s2} + (MW+1)'(524288);
		change = csum[MW:20];
		chg_e  = $signed({{(CW-CHW){1'b0}}, change});
		cur_e  = $signed({{(CW-TORQUE_WIDTH){cur_s2[TORQUE_WIDTH-1]}}, cur_s2});
		if (ctl.act == stsup_pkg::ACT_RAMP) begin
			tgt = '0;
		end else if (neg_s2) begin
			tgt = -$signed(mq);
		end else begin
			tgt = $signed(mq);
		end
		d = tgt - cur_e;
		if (d > chg_e) begin
			d = chg_e;
		end
		if (d < -chg_e) begin
			d = -chg_e;
		end
		nxt = cur_e + d;
		if (ctl.act == stsup_pkg::ACT_RAMP || ctl.act == stsup_pkg::ACT_SLEW) begin
			new_torque = nxt[TORQUE_WIDTH-1:0];
		end else begin
			new_torque = cur_s2;
		end
	end
endmodule
`default_nettype wire

### hdl/slew_limited_torque_supervisor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slew-limited torque supervisor
// Buffers joint items, decides once per period, and emits one torque per joint.
// ----------------------------------------------------------------------------
// Joint items are taken one per cycle while the walk is idle. The item marked
// last_joint closes the period; the emission walk then steps each joint through
// a memory read, a multiply, and an update with write back, and takes no new
// items until the last result of the period sits in the output register.
// Reset is asynchronous; valid bits make the torque store read zero and the
// limit tables read their largest values at once, with no clearing pass.
// ----------------------------------------------------------------------------
module slew_limited_torque_supervisor_core #(
	parameter int MAX_JOINTS   = stsup_pkg::MAX_JOINTS_DEF,
	parameter int TORQUE_WIDTH = stsup_pkg::TORQUE_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	stsup_in_if.sink                                   in_ch,
	stsup_out_if.source                                out_ch,
	input  wire logic                                  cfg_we,
	input  wire logic [stsup_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [stsup_pkg::CFG_W-1:0]           cfg_data
);
	localparam int AW   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	// The item counter saturates one past the joint maximum.
	localparam int CNTW = $clog2(MAX_JOINTS + 2);

	typedef enum logic [1:0] {
		WS_ACCEPT,
		WS_READ,
		WS_MUL,
		WS_WRITE
	} walk_state_t;

	// Configuration registers.
	logic [stsup_pkg::JCNT_W-1:0]    joint_count_q;
	logic [stsup_pkg::SLEW_W-1:0]    fault_slew_q;
	logic [stsup_pkg::JIDX_W-1:0]    lw_joint_q;
	logic [stsup_pkg::EFFORT_W-1:0]  lw_effort_q;

	// Period and supervisor state.
	logic [CNTW-1:0]                 item_cnt_q;
	stsup_pkg::flags_t               flags_q;
	logic                            fault_latched_q;
	logic                            ramp_q;
	stsup_pkg::drive_state_t         lvs_q;

	// Walk state.
	walk_state_t                     ws_q;
	logic [CNTW-1:0]                 k_q;
	logic [CNTW-1:0]                 n_q;
	stsup_pkg::act_t                 act_q;
	stsup_pkg::step_status_t         status_q;
	logic [stsup_pkg::PERIOD_W-1:0]  period_q;

	// Output register.
	logic                            ovld_q;
	logic [stsup_pkg::JIDX_W-1:0]    oidx_q;
	logic [TORQUE_WIDTH-1:0]         otq_q;
	stsup_pkg::step_status_t         ostat_q;
	logic                            olast_q;

	logic                            acc;
	stsup_pkg::drive_state_t         st;
	stsup_pkg::flags_t               f;
	logic [CNTW-1:0]                 cnt_nx;
	logic [CNTW-1:0]                 n_eff;
	logic                            match;
	logic                            valid;
	logic                            all_term;
	stsup_pkg::act_t                 dec_act;
	stsup_pkg::step_status_t         dec_status;
	logic                            latch_nx;
	logic                            ramp_nx;
	stsup_pkg::drive_state_t         lvs_nx;

	logic                            lim_we;
	logic                            tq_we;
	logic                            out_free;
	stsup_pkg::calc_ctl_t            ctl;

	logic [TORQUE_WIDTH-1:0]         rd_grav;
	logic [stsup_pkg::SCALE_W-1:0]   rd_scale;
	logic [stsup_pkg::EFFORT_W-1:0]  rd_effort;
	logic [stsup_pkg::SLEW_W-1:0]    rd_slew;
	logic [TORQUE_WIDTH-1:0]         rd_torque;
	logic [TORQUE_WIDTH-1:0]         new_torque;

	assign in_ch.ready = (ws_q == WS_ACCEPT);
	assign acc         = in_ch.valid && in_ch.ready;
	assign out_free    = !ovld_q || out_ch.ready;

	// A limit commit writes the pending effort and the new slew together.
	assign lim_we = cfg_we && (cfg_index == stsup_pkg::REG_LIMIT_SLEW) &&
		(int'(lw_joint_q) < MAX_JOINTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joint_count_q <= stsup_pkg::JOINT_COUNT_RST;
			fault_slew_q  <= stsup_pkg::FAULT_SLEW_RST;
			lw_joint_q    <= '0;
			lw_effort_q   <= stsup_pkg::EFFORT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				stsup_pkg::REG_JOINT_COUNT:  joint_count_q <= cfg_data[stsup_pkg::JCNT_W-1:0];
				stsup_pkg::REG_FAULT_SLEW:   fault_slew_q  <= cfg_data[stsup_pkg::SLEW_W-1:0];
				stsup_pkg::REG_LIMIT_JOINT:  lw_joint_q    <= cfg_data[stsup_pkg::JIDX_W-1:0];
				stsup_pkg::REG_LIMIT_EFFORT: lw_effort_q   <= cfg_data[stsup_pkg::EFFORT_W-1:0];
				default: ;
			endcase
		end
	end

	// Fold the incoming item into the period flags and take the period
	// decision in the same cycle as the last item of the period.
	always_comb begin
		st = stsup_pkg::drive_state_of(in_ch.status_word);
		f  = flags_q;
		if (st == stsup_pkg::DS_OP_ENABLED)     f.enabled  = 1'b1;
		if (st == stsup_pkg::DS_FAULT)          f.fault    = 1'b1;
		if (st == stsup_pkg::DS_FAULT_REACTION) f.reaction = 1'b1;
		if (st == stsup_pkg::DS_UNKNOWN)        f.unknown  = 1'b1;
		if (st != stsup_pkg::DS_SOD && st != stsup_pkg::DS_NOT_READY) f.terminal = 1'b0;
		if (in_ch.gain_scale > stsup_pkg::SCALE_ONE) f.badscale = 1'b1;

		cnt_nx = (int'(item_cnt_q) <= MAX_JOINTS) ? item_cnt_q + 1'b1 : item_cnt_q;

		if (joint_count_q == '0) begin
			n_eff = CNTW'(1);
		end else if (int'(joint_count_q) > MAX_JOINTS) begin
			n_eff = CNTW'(MAX_JOINTS);
		end else begin
			n_eff = CNTW'(joint_count_q);
		end
		match    = (cnt_nx == n_eff);
		valid    = match && (in_ch.period != '0) && !f.unknown && !f.badscale &&
			in_ch.model_ok;
		all_term = match && f.terminal;

		dec_act    = stsup_pkg::ACT_HOLD;
		dec_status = stsup_pkg::SS_OK;
		latch_nx   = fault_latched_q;
		ramp_nx    = ramp_q;
		lvs_nx     = lvs_q;
		if (fault_latched_q) begin
			// Already latched: only a running ramp keeps moving.
			dec_act    = ramp_q ? stsup_pkg::ACT_RAMP : stsup_pkg::ACT_HOLD;
			dec_status = stsup_pkg::SS_LATCHED;
		end else if (match && f.fault) begin
			dec_act    = stsup_pkg::ACT_ZERO;
			dec_status = stsup_pkg::SS_FAULT;
			latch_nx   = 1'b1;
			ramp_nx    = 1'b0;
			lvs_nx     = stsup_pkg::DS_FAULT;
		end else if (match && f.reaction) begin
			dec_status = stsup_pkg::SS_REACTION;
		end else if (!valid) begin
			// Invalid input ramps down only if the drives were last enabled.
			latch_nx   = 1'b1;
			ramp_nx    = (lvs_q == stsup_pkg::DS_OP_ENABLED);
			dec_act    = (lvs_q == stsup_pkg::DS_OP_ENABLED) ? stsup_pkg::ACT_RAMP
				: stsup_pkg::ACT_ZERO;
			dec_status = stsup_pkg::SS_INVALID;
		end else if (lvs_q == stsup_pkg::DS_OP_ENABLED && !f.enabled && !all_term) begin
			dec_status = stsup_pkg::SS_DISABLE;
		end else begin
			lvs_nx     = f.enabled ? stsup_pkg::DS_OP_ENABLED : st;
			dec_act    = stsup_pkg::ACT_SLEW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_cnt_q      <= '0;
			flags_q         <= stsup_pkg::FLAGS_RST;
			fault_latched_q <= 1'b0;
			ramp_q          <= 1'b0;
			lvs_q           <= stsup_pkg::DS_UNKNOWN;
		end else if (acc) begin
			if (in_ch.last_joint) begin
				item_cnt_q      <= '0;
				flags_q         <= stsup_pkg::FLAGS_RST;
				fault_latched_q <= latch_nx;
				ramp_q          <= ramp_nx;
				lvs_q           <= lvs_nx;
			end else begin
				item_cnt_q <= cnt_nx;
				flags_q    <= f;
			end
		end
	end

	// Walk over the joints: read the entry, multiply, then update and emit.
	// The output register lets the walk finish while the last word waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q     <= WS_ACCEPT;
			k_q      <= '0;
			n_q      <= '0;
			act_q    <= stsup_pkg::ACT_HOLD;
			status_q <= stsup_pkg::SS_OK;
			period_q <= '0;
			ovld_q   <= 1'b0;
			oidx_q   <= '0;
			otq_q    <= '0;
			ostat_q  <= stsup_pkg::SS_OK;
			olast_q  <= 1'b0;
		end else begin
			// Outside the write step the output word only drains.
			if (ws_q != WS_WRITE && out_ch.ready) begin
				ovld_q <= 1'b0;
			end
			unique case (ws_q)
				WS_ACCEPT: begin
					if (acc && in_ch.last_joint) begin
						k_q      <= '0;
						n_q      <= n_eff;
						act_q    <= dec_act;
						status_q <= dec_status;
						period_q <= in_ch.period;
						ws_q     <= WS_READ;
					end
				end
				WS_READ: begin
					ws_q <= WS_MUL;
				end
				WS_MUL: begin
					ws_q <= WS_WRITE;
				end
				WS_WRITE: begin
					if (out_free) begin
						ovld_q  <= 1'b1;
						oidx_q  <= stsup_pkg::JIDX_W'(k_q);
						otq_q   <= new_torque;
						ostat_q <= status_q;
						olast_q <= (k_q + 1'b1 == n_q);
						if (k_q + 1'b1 == n_q) begin
							ws_q <= WS_ACCEPT;
						end else begin
							k_q  <= k_q + 1'b1;
							ws_q <= WS_READ;
						end
					end
				end
				default: ws_q <= WS_ACCEPT;
			endcase
		end
	end

	assign tq_we = (ws_q == WS_WRITE) && out_free &&
		(act_q == stsup_pkg::ACT_RAMP || act_q == stsup_pkg::ACT_SLEW);

	assign ctl.mul_en = (ws_q == WS_MUL);
	assign ctl.act    = act_q;

	stsup_mem #(
		.MAX_JOINTS   (MAX_JOINTS),
		.TORQUE_WIDTH (TORQUE_WIDTH)
	) u_mem (
		.clk         (clk),
		.arst_n      (arst_n),
		.buf_we      (acc && (int'(item_cnt_q) < MAX_JOINTS)),
		.buf_waddr   (item_cnt_q[AW-1:0]),
		.buf_wgrav   (in_ch.gravity_torque),
		.buf_wscale  (in_ch.gain_scale),
		.lim_we      (lim_we),
		.lim_waddr   (AW'(lw_joint_q)),
		.lim_weffort (lw_effort_q),
		.lim_wslew   (cfg_data[stsup_pkg::SLEW_W-1:0]),
		.tq_we       (tq_we),
		.tq_waddr    (k_q[AW-1:0]),
		.tq_wdata    (new_torque),
		.tq_clear    (acc && in_ch.last_joint && (dec_act == stsup_pkg::ACT_ZERO)),
		.rd_addr     (k_q[AW-1:0]),
		.rd_grav     (rd_grav),
		.rd_scale    (rd_scale),
		.rd_effort   (rd_effort),
		.rd_slew     (rd_slew),
		.rd_torque   (rd_torque)
	);

	stsup_calc #(
		.TORQUE_WIDTH (TORQUE_WIDTH)
	) u_calc (
		.clk        (clk),
		.ctl        (ctl),
		.gravity    (rd_grav),
		.scale      (rd_scale),
		.effort     (rd_effort),
		.slew_tab   (rd_slew),
		.fault_slew (fault_slew_q),
		.period     (period_q),
		.cur_torque (rd_torque),
		.new_torque (new_torque)
	);

	assign out_ch.valid       = ovld_q;
	assign out_ch.joint_index = oidx_q;
	assign out_ch.torque_out  = otq_q;
	assign out_ch.step_status = ostat_q;
	assign out_ch.last_result = olast_q;
endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torque supervisor testbench
// Drives joint words through the valid/ready channels, predicts every result
// word from a behavioral copy of the supervisor, and compares them in order.
// ----------------------------------------------------------------------------
module tb_top;
	import stsup_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 40;

	// One expected result word.
	typedef struct {
		logic [JIDX_W-1:0] jidx;
		logic [23:0]       torque;
		step_status_t      status;
		logic              last;
	} torque_word_t;

	// Scoreboard: holds a private copy of the supervisor state and the queue
	// of torque words that the block still owes.
	class torque_scoreboard;
		longint       out_torque[8];
		longint       grav_buf[8];
		int unsigned  scale_buf[8];
		int unsigned  effort_tab[8];
		int unsigned  slew_tab[8];
		int unsigned  items_seen;
		flags_t       pflags;
		drive_state_t rep_state;
		drive_state_t last_good;
		bit           latched;
		bit           ramping;
		int unsigned  jcount;
		int unsigned  fslew;
		int unsigned  wr_joint;
		int unsigned  wr_effort;
		torque_word_t owed_q[$];
		int           failures;

		function new();
			for (int i = 0; i < 8; i++) begin
				out_torque[i] = 0;
				grav_buf[i]   = 0;
				scale_buf[i]  = 0;
				effort_tab[i] = 8388607;
				slew_tab[i]   = 16777215;
			end
			items_seen = 0;
			pflags     = FLAGS_RST;
			rep_state  = DS_UNKNOWN;
			last_good  = DS_UNKNOWN;
			latched    = 0;
			ramping    = 0;
			jcount     = 6;
			fslew      = 1024;
			wr_joint   = 0;
			wr_effort  = 8388607;
			failures   = 0;
		endfunction

		function drive_state_t decode(logic [15:0] sw);
			logic [15:0] lo;
			logic [15:0] hi;
			lo = sw & 16'h004F;
			hi = sw & 16'h006F;
			if (lo == 16'h0000) return DS_NOT_READY;
			if (lo == 16'h0040) return DS_SOD;
			if (hi == 16'h0021) return DS_READY;
			if (hi == 16'h0023) return DS_SWITCHED_ON;
			if (hi == 16'h0027) return DS_OP_ENABLED;
			if (hi == 16'h0007) return DS_QUICK_STOP;
			if (lo == 16'h000F) return DS_FAULT_REACTION;
			if (lo == 16'h0008) return DS_FAULT;
			return DS_UNKNOWN;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_JOINT_COUNT:  jcount = v[3:0];
				REG_FAULT_SLEW:   fslew = v;
				REG_LIMIT_JOINT:  wr_joint = v[2:0];
				REG_LIMIT_EFFORT: wr_effort = v[22:0];
				REG_LIMIT_SLEW: begin
					effort_tab[wr_joint] = wr_effort;
					slew_tab[wr_joint]   = v;
				end
				default: ;
			endcase
		endfunction

		// Rounded per-period step, halves rounded up.
		function longint change_of(longint slew, longint per);
			return (slew * per + (longint'(1) << 19)) >>> 20;
		endfunction

		function longint move_toward(longint cur, longint tgt, longint ch);
			longint d;
			d = tgt - cur;
			if (d > ch) d = ch;
			if (d < -ch) d = -ch;
			return cur + d;
		endfunction

		// Scaled gravity torque with halves away from zero, clamped to the effort.
		function longint target_of(int j);
			longint mag;
			longint q;
			longint lim;
			mag = (grav_buf[j] < 0) ? -grav_buf[j] : grav_buf[j];
			q   = (longint'(scale_buf[j]) * mag + 32768) >>> 16;
			lim = effort_tab[j];
			if (lim > 8388607) lim = 8388607;
			if (q > lim) q = lim;
			return (grav_buf[j] < 0) ? -q : q;
		endfunction

		function void ramp_down(int n, longint per);
			longint ch;
			ch = change_of(fslew, per);
			for (int i = 0; i < n; i++) out_torque[i] = move_toward(out_torque[i], 0, ch);
		endfunction

		function void note_item(logic signed [23:0] g, logic [16:0] sc, logic [15:0] sw,
				logic mv, logic [15:0] per, logic last);
			drive_state_t st;
			step_status_t status;
			flags_t       fl;
			int           n;
			bit           match;
			bit           good;
			bit           all_term;
			torque_word_t w;
			st = decode(sw);
			if (items_seen < 8) begin
				grav_buf[items_seen]  = g;
				scale_buf[items_seen] = sc;
			end
			if (st == DS_OP_ENABLED) pflags.enabled = 1;
			if (st == DS_FAULT) pflags.fault = 1;
			if (st == DS_FAULT_REACTION) pflags.reaction = 1;
			if (st == DS_UNKNOWN) pflags.unknown = 1;
			if (st != DS_SOD && st != DS_NOT_READY) pflags.terminal = 0;
			if (sc > 65536) pflags.badscale = 1;
			rep_state = st;
			if (items_seen <= 8) items_seen++;
			if (!last) return;

			n = jcount;
			if (n < 1) n = 1;
			if (n > 8) n = 8;
			match      = (items_seen == n);
			fl         = pflags;
			items_seen = 0;
			pflags     = FLAGS_RST;

			if (latched) begin
				if (ramping) ramp_down(n, per);
				status = SS_LATCHED;
			end else if (match && fl.fault) begin
				for (int i = 0; i < 8; i++) out_torque[i] = 0;
				latched   = 1;
				ramping   = 0;
				last_good = DS_FAULT;
				status    = SS_FAULT;
			end else if (match && fl.reaction) begin
				status = SS_REACTION;
			end else begin
				good     = match && per != 0 && !fl.unknown && !fl.badscale && mv;
				all_term = match && fl.terminal;
				if (!good) begin
					latched = 1;
					ramping = (last_good == DS_OP_ENABLED);
					if (ramping) ramp_down(n, per);
					else for (int i = 0; i < 8; i++) out_torque[i] = 0;
					status = SS_INVALID;
				end else if (last_good == DS_OP_ENABLED && !fl.enabled && !all_term) begin
					status = SS_DISABLE;
				end else begin
					last_good = fl.enabled ? DS_OP_ENABLED : rep_state;
					for (int k = 0; k < n; k++)
						out_torque[k] = move_toward(out_torque[k], target_of(k),
							change_of(slew_tab[k], per));
					status = SS_OK;
				end
			end
			for (int k = 0; k < n; k++) begin
				w.jidx   = JIDX_W'(k);
				w.torque = out_torque[k][23:0];
				w.status = status;
				w.last   = (k == n - 1);
				owed_q.push_back(w);
			end
		endfunction

		function void check_result(logic [JIDX_W-1:0] jidx, logic [23:0] torque,
				logic [STEP_W-1:0] status, logic last);
			torque_word_t w;
			if (owed_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result word: joint %0d torque %0d status %0d",
						jidx, $signed(torque), status);
				return;
			end
			w = owed_q.pop_front();
			if (jidx !== w.jidx || torque !== w.torque || status !== w.status ||
					last !== w.last) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: expected j%0d t%0d s%0d l%0d, got j%0d t%0d s%0d l%0d",
						w.jidx, $signed(w.torque), w.status, w.last,
						jidx, $signed(torque), status, last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	stsup_in_if  in_ch ();
	stsup_out_if out_ch ();

	slew_limited_torque_supervisor_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch.sink),
		.out_ch    (out_ch.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	torque_scoreboard sb;
	bit idle_on;
	bit long_hold_req;
	int hold_left;
	int eff_n;
	int unsigned cycles;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Every input starts at a known value before the first edge.
	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		in_ch.valid          = 1'b0;
		in_ch.gravity_torque = '0;
		in_ch.gain_scale     = '0;
		in_ch.status_word    = '0;
		in_ch.model_ok       = 1'b0;
		in_ch.period         = '0;
		in_ch.last_joint     = 1'b0;
		out_ch.ready         = 1'b0;
		idle_on              = 1'b1;
		long_hold_req        = 1'b0;
		hold_left            = 0;
		cycles               = 0;
		sb                   = new();
	end

	// A run that does not finish in time is a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result receiver. It stalls in short random bursts while idling is on, and
	// once holds off for a long stretch so that the block backs up into its
	// input channel.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left     = LONG_HOLD;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 15) == 0) begin
			hold_left = $urandom_range(0, 10);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Monitors sample the handshake at the edge, before any update lands, so
	// every accepted word is seen exactly once.
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			sb.note_item(in_ch.gravity_torque, in_ch.gain_scale, in_ch.status_word,
				in_ch.model_ok, in_ch.period, in_ch.last_joint);
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.joint_index, out_ch.torque_out, out_ch.step_status,
				out_ch.last_result);
	end

	// Register write; the enable drops on the following edge.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(int j, int unsigned effort, int unsigned slew);
		write_reg(REG_LIMIT_JOINT, CFG_W'(j));
		write_reg(REG_LIMIT_EFFORT, CFG_W'(effort));
		write_reg(REG_LIMIT_SLEW, CFG_W'(slew));
	endtask

	task automatic set_joints(int unsigned n);
		write_reg(REG_JOINT_COUNT, CFG_W'(n));
		eff_n = (n < 1) ? 1 : (n > 8) ? 8 : int'(n);
	endtask

	// Offer one joint word and wait until it is taken.
	task automatic send_word(logic signed [23:0] g, logic [16:0] sc, logic [15:0] sw,
			logic mv, logic [15:0] per, logic last);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.gravity_torque <= g;
		in_ch.gain_scale     <= sc;
		in_ch.status_word    <= sw;
		in_ch.model_ok       <= mv;
		in_ch.period         <= per;
		in_ch.last_joint     <= last;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Sender pauses until every owed word has come, then lets the block settle.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.owed_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Status word for a drive state, with the don't-care bits random.
	function automatic logic [15:0] word_for(drive_state_t s);
		logic [15:0] r;
		r = 16'($urandom);
		case (s)
			DS_NOT_READY:      return (r & ~SW_MASK_A) | SW_NOT_READY;
			DS_SOD:            return (r & ~SW_MASK_A) | SW_SOD;
			DS_READY:          return (r & ~SW_MASK_B) | SW_READY;
			DS_SWITCHED_ON:    return (r & ~SW_MASK_B) | SW_SWITCHED_ON;
			DS_OP_ENABLED:     return (r & ~SW_MASK_B) | SW_OP_ENABLED;
			DS_QUICK_STOP:     return (r & ~SW_MASK_B) | SW_QUICK_STOP;
			DS_FAULT_REACTION: return (r & ~SW_MASK_A) | SW_FAULT_REACT;
			DS_FAULT:          return (r & ~SW_MASK_A) | SW_FAULT;
			default: begin
				while (sb.decode(r) != DS_UNKNOWN) r = 16'($urandom);
				return r;
			end
		endcase
	endfunction

	function automatic logic signed [23:0] any_gravity();
		case ($urandom_range(0, 9))
			0:       return 24'sh7FFFFF;
			1:       return 24'sh800000;
			2:       return 24'($urandom_range(0, 2000) - 1000);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [16:0] good_scale();
		case ($urandom_range(0, 7))
			0:       return SCALE_ONE;
			1:       return 17'd0;
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [15:0] good_period();
		case ($urandom_range(0, 3))
			0:       return 16'($urandom_range(1, 65535));
			default: return 16'($urandom_range(1, 2000));
		endcase
	endfunction

	// A well-formed period of eff_n words. Mode picks the drive states:
	// 0 random among the states that do not latch, 1 all operation enabled,
	// 2 all switched on (drops the enable), 3 one fault reaction, 4 all
	// terminal states.
	task automatic run_period(int mode);
		drive_state_t s;
		logic         last;
		for (int i = 0; i < eff_n; i++) begin
			case (mode)
				1: s = DS_OP_ENABLED;
				2: s = DS_SWITCHED_ON;
				3: s = (i == 0) ? DS_FAULT_REACTION : DS_OP_ENABLED;
				4: s = ($urandom_range(0, 1) != 0) ? DS_SOD : DS_NOT_READY;
				default: begin
					case ($urandom_range(0, 11))
						0: s = DS_NOT_READY;
						1: s = DS_SOD;
						2: s = DS_READY;
						3: s = DS_SWITCHED_ON;
						4: s = DS_QUICK_STOP;
						5: s = DS_FAULT_REACTION;
						default: s = DS_OP_ENABLED;
					endcase
				end
			endcase
			last = (i == eff_n - 1);
			send_word(any_gravity(), good_scale(), word_for(s),
				last ? 1'b1 : 1'($urandom_range(0, 1)),
				last ? good_period() : 16'($urandom), last);
		end
	endtask

	initial begin : stimulus
		int kind;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		eff_n = 6;

		// Directed part with the reset configuration: extreme torques at full
		// scale, then a drop of the enable (disable hold), a fault reaction
		// (hold), and a period in which every drive sits in a terminal state.
		send_word(24'sh7FFFFF, SCALE_ONE, word_for(DS_OP_ENABLED), 1'b1, 16'hFFFF, 1'b0);
		send_word(24'sh800000, SCALE_ONE, word_for(DS_OP_ENABLED), 1'b0, 16'hFFFF, 1'b0);
		send_word(24'sd0, 17'd0, word_for(DS_OP_ENABLED), 1'b1, 16'h0000, 1'b0);
		send_word(24'sd1, 17'd32768, word_for(DS_OP_ENABLED), 1'b0, 16'h0001, 1'b0);
		send_word(-24'sd1, 17'd32768, word_for(DS_OP_ENABLED), 1'b1, 16'h8000, 1'b0);
		send_word(24'sd3, 17'd43690, word_for(DS_OP_ENABLED), 1'b1, 16'hFFFF, 1'b1);
		run_period(2);
		run_period(3);
		run_period(4);
		drain();

		// Limit tables and fault slew at their extremes, with eight joints.
		write_reg(REG_FAULT_SLEW, 24'hFFFFFF);
		set_limits(0, 1, 1);
		set_limits(7, 23'h7FFFFF, 24'hFFFFFF);
		set_limits(3, 1000, 50000);
		set_limits($urandom_range(1, 6), $urandom_range(1, 8388607),
			$urandom_range(1, 16777215));
		set_joints(8);
		run_period(1);

		// Long receiver hold-off while the sender keeps offering full periods.
		long_hold_req = 1'b1;
		repeat (3) run_period(0);
		drain();

		// Random part: mostly well-formed periods, joint count changed between
		// phases, including the out-of-range values that clamp.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_joints(0);
				1: set_joints(15);
				2: set_joints(1);
				default: set_joints($urandom_range(1, 8));
			endcase
			write_reg(REG_FAULT_SLEW, CFG_W'($urandom_range(1, 16777215)));
			set_limits($urandom_range(0, 7), $urandom_range(1, 8388607),
				$urandom_range(1, 16777215));
			for (int p = 0; p < 2; p++) run_period(($urandom_range(0, 4) == 0) ? 2 : 0);
			drain();
		end

		// Closing part, no idling: enable once, then break a period so the
		// supervisor latches, then feed noise while it stays latched.
		idle_on = 1'b0;
		write_reg(REG_FAULT_SLEW, ($urandom_range(0, 1) != 0) ? 24'd1 : 24'($urandom));
		set_joints(4);
		run_period(1);
		kind = $urandom_range(0, 5);
		for (int i = 0; i < 4; i++) begin
			logic last;
			last = (kind == 4) ? (i == 2) : (i == 3);
			if (kind == 4 && i == 3) break;
			send_word(any_gravity(),
				(kind == 2 && i == 1) ? 17'($urandom_range(65537, 131071)) : good_scale(),
				word_for((kind == 0 && i == 2) ? DS_FAULT :
					(kind == 1 && i == 0) ? DS_UNKNOWN : DS_OP_ENABLED),
				(kind == 5 && last) ? 1'b0 : 1'b1,
				(kind == 3 && last) ? 16'h0000 : good_period(), last);
		end
		for (int p = 0; p < 3; p++) begin
			int cnt;
			cnt = $urandom_range(1, 6);
			for (int i = 0; i < cnt; i++)
				send_word(24'($urandom), 17'($urandom), 16'($urandom), 1'($urandom),
					(p == 0) ? 16'h0000 : 16'($urandom), i == cnt - 1);
		end
		drain();

		if (sb.failures == 0 && sb.owed_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

### filelist.f
hdl/stsup_pkg.sv
hdl/stsup_in_if.sv
hdl/stsup_out_if.sv
hdl/stsup_mem.sv
hdl/stsup_calc.sv
hdl/slew_limited_torque_supervisor_core.sv
verif/tb_top.sv
